// ===== src/assert_macros.svh =====
// Assertion shorthands shared by the console RTL.
// Both expect clk_i and rst_ni to be in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define TCW_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition that must be followed by another one on the next clock edge.
`define TCW_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/tcw_pkg.sv =====
`timescale 1ns / 1ps

package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELLS      = ROWS * COLUMNS;
  localparam int ADDR_W     = $clog2(CELLS);

  localparam int REQ_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int CELL_W     = 16;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int COLOR_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = ((IDX_W > ADDR_W) ? IDX_W : ADDR_W) + 1;

  localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CHAR_W-1:0] RESET_ATTR   = 8'h0F;

  localparam logic [CFG_IDX_W-1:0] CFG_FOREGROUND = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND = 2'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUT   = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_e;

  typedef struct packed {
    logic accept;
    logic sweep_step;
    logic sweep_init;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic sweep_start;
    logic sweep_last;
  } status_t;

endpackage

// ===== src/tcw_ram.sv =====
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/tcw_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tcw_pkg::cmd_t                 cmd_i,
  output tcw_pkg::status_t              status_o,
  input  logic [tcw_pkg::REQ_W-1:0]     req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]     cell_index_i,
  input  logic                          cfg_valid_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data_i,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data_o,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]     cursor_col_o,
  output logic                          did_scroll_o
);

  import tcw_pkg::*;

  logic [COLOR_W-1:0] fg_q, fg_d, bg_q, bg_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ADDR_W-1:0]  row_base_q, row_base_d;
  logic [ADDR_W-1:0]  top_q, top_d;
  logic [ADDR_W-1:0]  sweep_addr_q, sweep_addr_d;
  logic [ADDR_W-1:0]  sweep_left_q, sweep_left_d;
  logic               scroll_q, scroll_d;
  logic               rd_ok_q, rd_ok_d;

  logic [CELL_W-1:0]  cell_data_q;
  logic [ROW_W-1:0]   row_out_q;
  logic [COL_W-1:0]   col_out_q;
  logic               scroll_out_q;

  req_e               req;
  logic [CHAR_W-1:0]  attr;
  logic               is_put, is_clear, is_read;
  logic               newline, wrap, last_row, scroll_now, idx_ok;
  logic [COL_W:0]     col_inc;
  logic [SUM_W-1:0]   cur_sum, rd_sum, top_sum;
  logic [ADDR_W-1:0]  cur_addr, rd_addr, top_next;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  assign req      = req_e'(req_type_i);
  assign attr     = {bg_q, fg_q};
  assign is_put   = cmd_i.accept && (req == REQ_PUT);
  assign is_clear = cmd_i.accept && (req == REQ_CLEAR);
  assign is_read  = cmd_i.accept && (req == REQ_READ);

  assign newline    = (char_code_i == NEWLINE_CHAR);
  assign col_inc    = {1'b0, col_q} + (COL_W+1)'(1);
  assign wrap       = newline || (col_inc == (COL_W+1)'(COLUMNS));
  assign last_row   = (row_q == ROW_W'(ROWS - 1));
  assign scroll_now = is_put && wrap && last_row;

  // The screen is a ring of rows: top_q is the store address of the row shown on top.
  assign cur_sum  = SUM_W'(row_base_q) + SUM_W'(col_q) + SUM_W'(top_q);
  assign cur_addr = (cur_sum >= SUM_W'(CELLS)) ? ADDR_W'(cur_sum - SUM_W'(CELLS))
                                               : ADDR_W'(cur_sum);
  assign idx_ok   = (SUM_W'(cell_index_i) < SUM_W'(CELLS));
  assign rd_sum   = SUM_W'(cell_index_i) + SUM_W'(top_q);
  assign rd_addr  = (rd_sum >= SUM_W'(CELLS)) ? ADDR_W'(rd_sum - SUM_W'(CELLS))
                                              : ADDR_W'(rd_sum);
  assign top_sum  = SUM_W'(top_q) + SUM_W'(COLUMNS);
  assign top_next = (top_sum >= SUM_W'(CELLS)) ? ADDR_W'(top_sum - SUM_W'(CELLS))
                                               : ADDR_W'(top_sum);

  assign status_o.sweep_start = scroll_now || is_clear;
  assign status_o.sweep_last  = (sweep_left_q == '0);

  always_comb begin
    fg_d         = fg_q;
    bg_d         = bg_q;
    row_d        = row_q;
    col_d        = col_q;
    row_base_d   = row_base_q;
    top_d        = top_q;
    sweep_addr_d = sweep_addr_q;
    sweep_left_d = sweep_left_q;
    scroll_d     = scroll_q;
    rd_ok_d      = rd_ok_q;

    if (cfg_valid_i && (cfg_index_i == CFG_FOREGROUND)) begin
      fg_d = cfg_data_i;
    end
    if (cfg_valid_i && (cfg_index_i == CFG_BACKGROUND)) begin
      bg_d = cfg_data_i;
    end

    if (cmd_i.accept) begin
      scroll_d = scroll_now;
      rd_ok_d  = is_read && idx_ok;
      unique case (req)
        REQ_PUT: begin
          if (wrap) begin
            col_d = '0;
            if (last_row) begin
              top_d        = top_next;
              sweep_addr_d = top_q;
              sweep_left_d = ADDR_W'(COLUMNS - 1);
            end else begin
              row_d      = row_q + ROW_W'(1);
              row_base_d = row_base_q + ADDR_W'(COLUMNS);
            end
          end else begin
            col_d = col_inc[COL_W-1:0];
          end
        end
        REQ_CLEAR: begin
          row_d        = '0;
          col_d        = '0;
          row_base_d   = '0;
          top_d        = '0;
          sweep_addr_d = '0;
          sweep_left_d = ADDR_W'(CELLS - 1);
        end
        REQ_READ, REQ_NOP: begin
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.sweep_step) begin
      sweep_addr_d = sweep_addr_q + ADDR_W'(1);
      sweep_left_d = sweep_left_q - ADDR_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q         <= RESET_ATTR[COLOR_W-1:0];
      bg_q         <= RESET_ATTR[CHAR_W-1:COLOR_W];
      row_q        <= '0;
      col_q        <= '0;
      row_base_q   <= '0;
      top_q        <= '0;
      sweep_addr_q <= '0;
      sweep_left_q <= ADDR_W'(CELLS - 1);
      scroll_q     <= 1'b0;
      rd_ok_q      <= 1'b0;
    end else begin
      fg_q         <= fg_d;
      bg_q         <= bg_d;
      row_q        <= row_d;
      col_q        <= col_d;
      row_base_q   <= row_base_d;
      top_q        <= top_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_left_q <= sweep_left_d;
      scroll_q     <= scroll_d;
      rd_ok_q      <= rd_ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      cell_data_q  <= rd_ok_q ? ram_rdata : '0;
      row_out_q    <= row_q;
      col_out_q    <= col_q;
      scroll_out_q <= scroll_q;
    end
  end

  assign ram_we    = cmd_i.sweep_step || (is_put && !newline);
  assign ram_waddr = cmd_i.sweep_step ? sweep_addr_q : cur_addr;
  assign ram_wdata = cmd_i.sweep_step ? {(cmd_i.sweep_init ? RESET_ATTR : attr), BLANK_CHAR}
                                      : {attr, char_code_i};

  tcw_ram #(
    .WIDTH(CELL_W),
    .DEPTH(CELLS)
  ) u_screen (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (is_read),
    .raddr_i(rd_addr),
    .rdata_o(ram_rdata)
  );

  assign cell_data_o  = cell_data_q;
  assign cursor_row_o = row_out_q;
  assign cursor_col_o = col_out_q;
  assign did_scroll_o = scroll_out_q;

  `TCW_ASSERT(a_row_base, row_base_q == ADDR_W'(row_q) * ADDR_W'(COLUMNS), "row base out of step")
  `TCW_ASSERT(a_cursor_range, int'(row_q) < ROWS && int'(col_q) < COLUMNS, "cursor off screen")
  `TCW_ASSERT_NEXT(a_sweep_count, cmd_i.sweep_step && !status_o.sweep_last,
                   sweep_left_q == $past(sweep_left_q) - ADDR_W'(1), "sweep count skipped")

endmodule

// ===== src/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tcw_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  tcw_pkg::status_t status_i,
  output tcw_pkg::cmd_t    cmd_o
);

  import tcw_pkg::*;

  typedef enum logic [3:0] {
    S_INIT  = 4'b0001,
    S_IDLE  = 4'b0010,
    S_BLANK = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        cmd_o.sweep_init = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = status_i.sweep_start ? S_BLANK : S_DONE;
        end
      end
      S_BLANK: begin
        cmd_o.sweep_step = 1'b1;
        if (status_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_INIT;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `TCW_ASSERT_NEXT(a_accept_moves_on, state_q == S_IDLE && in_valid_i,
                   state_q == S_BLANK || state_q == S_DONE, "request not taken up")
  `TCW_ASSERT_NEXT(a_sweep_finishes, state_q == S_BLANK && status_i.sweep_last,
                   state_q == S_DONE, "blanking did not end")

endmodule

// ===== src/text_console_writer.sv =====
`timescale 1ns / 1ps
// Character-cell text console with an 80 x 25 screen store of 16-bit cells.
// Requests arrive on the in channel (req_type, char_code, cell_index) with
// valid and ready; each request gives exactly one result on the out channel
// (cell_data, cursor_row, cursor_col, did_scroll), held in an output register.
// A put, read or unused request is taken in S_IDLE, and its result is loaded
// in S_DONE once the output register is free, after which in_ready_o rises again.
// A put that scrolls also blanks 80 cells and a clear blanks 2000 cells in S_BLANK,
// one cell a cycle through the single write port of the screen store.
// Scrolling moves a top-row pointer, so only the new bottom row is rewritten.
// After reset the block fills all 2000 cells of the store with blanks in S_INIT,
// with in_ready_o low; configuration writes are taken throughout.
// If the receiver stalls, the result waits in the output register; the next
// request is still taken, and its result is loaded once the waiting one can be replaced.
// The colour registers are written on the cfg channel, index 0 foreground and
// index 1 background; cfg_ready_o is always high and other indexes are ignored.

module text_console_writer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [tcw_pkg::REQ_W-1:0]     req_type_i,
  input  logic [tcw_pkg::CHAR_W-1:0]    char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]     cell_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [tcw_pkg::CELL_W-1:0]    cell_data_o,
  output logic [tcw_pkg::ROW_W-1:0]     cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]     cursor_col_o,
  output logic                          did_scroll_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [tcw_pkg::COLOR_W-1:0]   cfg_data_i
);

  import tcw_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tcw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .req_type_i  (req_type_i),
    .char_code_i (char_code_i),
    .cell_index_i(cell_index_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cell_data_o (cell_data_o),
    .cursor_row_o(cursor_row_o),
    .cursor_col_o(cursor_col_o),
    .did_scroll_o(did_scroll_o)
  );

endmodule

// ===== test/tb_text_console_writer.sv =====
`timescale 1ns / 1ps

module tb_text_console_writer;
  import tcw_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_REQUESTS = 170;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [CELL_W-1:0] data_word;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              scrolled;
  } console_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [REQ_W-1:0]     req_type_i = '0;
  logic [CHAR_W-1:0]    char_code_i = '0;
  logic [IDX_W-1:0]     cell_index_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [CELL_W-1:0]    cell_data_o;
  logic [ROW_W-1:0]     cursor_row_o;
  logic [COL_W-1:0]     cursor_col_o;
  logic                 did_scroll_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [COLOR_W-1:0]   cfg_data_i = '0;

  logic [CELL_W-1:0]    shadow_cells [CELLS];
  int                   shadow_row;
  int                   shadow_col;
  logic [COLOR_W-1:0]   shadow_fg;
  logic [COLOR_W-1:0]   shadow_bg;

  console_result_t      pending_results [$];
  int                   requests_sent = 0;
  int                   mismatch_count = 0;
  int                   quiet_cycles = 0;
  bit                   stall_free = 1'b0;

  text_console_writer uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .char_code_i  (char_code_i),
    .cell_index_i (cell_index_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cell_data_o  (cell_data_o),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .did_scroll_o (did_scroll_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic console_result_t advance_console(input req_e kind,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [IDX_W-1:0] idx);
    console_result_t   res;
    logic [CELL_W-1:0] attr_cell;
    int                pos;
    res = '0;
    attr_cell = {shadow_bg, shadow_fg, 8'h00};
    case (kind)
      REQ_PUT: begin
        if (ch == NEWLINE_CHAR) begin
          shadow_col = 0;
          shadow_row++;
        end else begin
          pos = shadow_row * COLUMNS + shadow_col;
          if (pos < CELLS) begin
            shadow_cells[pos] = attr_cell | CELL_W'(ch);
          end
          shadow_col++;
          if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
          end
        end
        if (shadow_row >= ROWS) begin
          for (int i = 0; i < CELLS - COLUMNS; i++) begin
            shadow_cells[i] = shadow_cells[i + COLUMNS];
          end
          for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
            shadow_cells[i] = attr_cell | CELL_W'(BLANK_CHAR);
          end
          shadow_row = ROWS - 1;
          res.scrolled = 1'b1;
        end
      end
      REQ_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          shadow_cells[i] = attr_cell | CELL_W'(BLANK_CHAR);
        end
        shadow_row = 0;
        shadow_col = 0;
      end
      REQ_READ: begin
        if (idx < CELLS) begin
          res.data_word = shadow_cells[idx];
        end
      end
      default: begin
      end
    endcase
    res.row = ROW_W'(shadow_row);
    res.col = COL_W'(shadow_col);
    return res;
  endfunction

  task automatic send_request(input req_e kind, input logic [CHAR_W-1:0] ch,
                              input logic [IDX_W-1:0] idx);
    if (!stall_free && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 30);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= kind;
    char_code_i  <= ch;
    cell_index_i <= idx;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(advance_console(kind, ch, idx));
    requests_sent++;
  endtask

  task automatic drain_requests();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_colour_reg(input logic [CFG_IDX_W-1:0] index,
                                  input logic [COLOR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (index == CFG_FOREGROUND) begin
      shadow_fg = value;
    end else if (index == CFG_BACKGROUND) begin
      shadow_bg = value;
    end
  endtask

  // Colours are only changed once every outstanding request has been answered.
  task automatic program_colours(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg);
    drain_requests();
    write_colour_reg(CFG_FOREGROUND, fg);
    write_colour_reg($urandom_range(1) ? CFG_SPARE_HI : CFG_SPARE_LO, COLOR_W'($urandom));
    write_colour_reg(CFG_BACKGROUND, bg);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_reset_contents();
    send_request(REQ_READ, 8'h00, 11'd0);
    send_request(REQ_READ, 8'hFF, 11'(CELLS - 1));
    send_request(REQ_READ, 8'h00, 11'(CELLS));
    send_request(REQ_READ, 8'h00, 11'h7FF);
    send_request(REQ_NOP, 8'($urandom), 11'($urandom));
  endtask

  task automatic test_colour_extremes();
    program_colours(4'h0, 4'hF);
    send_request(REQ_PUT, 8'h00, 11'h000);
    send_request(REQ_PUT, 8'hFF, 11'h7FF);
    send_request(REQ_PUT, 8'h41, 11'd0);
    send_request(REQ_READ, 8'h00, 11'd0);
    send_request(REQ_READ, 8'h00, 11'd1);
    send_request(REQ_READ, 8'h00, 11'd2);
    send_request(REQ_PUT, NEWLINE_CHAR, 11'd0);
    send_request(REQ_READ, 8'h00, 11'(COLUMNS));
    send_request(REQ_CLEAR, 8'hFF, 11'h7FF);
    send_request(REQ_READ, 8'h00, 11'(CELLS - 1));
    send_request(REQ_READ, 8'h00, 11'd0);
    program_colours(4'hF, 4'h0);
    send_request(REQ_PUT, 8'h7E, 11'd0);
    send_request(REQ_READ, 8'h00, 11'd0);
  endtask

  // Mostly runs of text, newline runs and reads near the cursor, with some noise.
  task automatic run_mixed_traffic(input int budget);
    int target;
    int pick;
    int len;
    int row_pick;
    target = requests_sent + budget;
    while (requests_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        len = $urandom_range(100, 1);
        repeat (len) begin
          send_request(REQ_PUT, ($urandom_range(9) == 0) ? 8'($urandom)
                                : 8'($urandom_range(126, 32)), 11'($urandom));
        end
      end else if (pick < 60) begin
        len = $urandom_range(30, 1);
        repeat (len) send_request(REQ_PUT, NEWLINE_CHAR, 11'($urandom));
      end else if (pick < 85) begin
        len = $urandom_range(8, 1);
        repeat (len) begin
          if ($urandom_range(1)) begin
            row_pick = $urandom_range(shadow_row);
            send_request(REQ_READ, 8'($urandom),
                         11'(row_pick * COLUMNS + $urandom_range(COLUMNS - 1)));
          end else begin
            send_request(REQ_READ, 8'($urandom), 11'($urandom_range(2047)));
          end
        end
      end else if (pick < 87) begin
        send_request(REQ_CLEAR, 8'($urandom), 11'($urandom));
      end else begin
        send_request(req_e'($urandom_range(3)), 8'($urandom), 11'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: program_colours(4'h0, 4'h0);
        1: program_colours(4'hF, 4'hF);
        default: program_colours(COLOR_W'($urandom), COLOR_W'($urandom));
      endcase
      stall_free = (phase == 2);
      run_mixed_traffic(PHASE_REQUESTS);
    end
    stall_free = 1'b0;
    drain_requests();
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= stall_free || ($urandom_range(99) >= 30);
  end

  always @(posedge clk_i) begin : check_results
    console_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("Result arrived with no request outstanding");
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (cell_data_o !== want.data_word) begin
          $error("cell_data: expected %h, got %h", want.data_word, cell_data_o);
          mismatch_count++;
        end
        if (cursor_row_o !== want.row) begin
          $error("cursor_row: expected %0d, got %0d", want.row, cursor_row_o);
          mismatch_count++;
        end
        if (cursor_col_o !== want.col) begin
          $error("cursor_col: expected %0d, got %0d", want.col, cursor_col_o);
          mismatch_count++;
        end
        if (did_scroll_o !== want.scrolled) begin
          $error("did_scroll: expected %0d, got %0d", want.scrolled, did_scroll_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CELLS; i++) begin
      shadow_cells[i] = {RESET_ATTR, BLANK_CHAR};
    end
    shadow_row = 0;
    shadow_col = 0;
    shadow_fg = 4'hF;
    shadow_bg = 4'h0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_contents();
    test_colour_extremes();
    test_random_phases();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
